FILE: src/tpdc_pkg.sv
// Shared types and constants for the three-point distance calibration block.
package tpdc_pkg;

  localparam int RAW_W  = 16;
  localparam int OUT_W  = 14;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_RAW_NEAR    = 3'd0,
    REG_RAW_MID     = 3'd1,
    REG_RAW_FAR     = 3'd2,
    REG_TABLE_VALID = 3'd3,
    REG_BODY_REF    = 3'd4,
    REG_MIN_GAP_NM  = 3'd5,
    REG_MIN_GAP_MF  = 3'd6
  } reg_idx_t;

  // Calibration view handed from the register file to the datapath.
  typedef struct packed {
    logic [RAW_W-1:0] raw_near;
    logic [RAW_W-1:0] raw_mid;
    logic [RAW_W-1:0] span_nm;
    logic [RAW_W-1:0] span_mf;
    logic             body_ref;
    logic             usable;
  } cal_t;

endpackage

FILE: src/three_point_distance_calibration.sv
// Top level of the three-point piecewise-linear distance calibration.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid/in_stall    raw_mm
//   out       source     out_valid/out_stall  corrected_mm, ok
//   apb       slave      psel/penable/pready  paddr, pwdata, prdata
//
// One sample enters per cycle while in_stall is low, and each gives one result;
// it passes the front stages, the bit-per-stage divider, the back end and out.
// rst is synchronous; it clears all valid bits and loads the register defaults.
// A stall on out parks one result in a skid register; in_stall then rises
// and the whole pipeline holds until the skid entry has gone out.
module three_point_distance_calibration #(
  parameter int TARGET_NEAR = 100,
  parameter int TARGET_MID  = 300,
  parameter int TARGET_FAR  = 500,
  parameter int BODY_OFFSET = 75,
  parameter int DISPLAY_MAX = 9999
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tpdc_pkg::RAW_W-1:0]   raw_mm,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tpdc_pkg::OUT_W-1:0]   corrected_mm,
  output logic                         ok,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpdc_pkg::DATA_W-1:0]  pwdata,
  output logic [tpdc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import tpdc_pkg::*;

  localparam int DT_NM_ABS = (TARGET_MID >= TARGET_NEAR) ?
                             (TARGET_MID - TARGET_NEAR) : (TARGET_NEAR - TARGET_MID);
  localparam int DT_MF_ABS = (TARGET_FAR >= TARGET_MID) ?
                             (TARGET_FAR - TARGET_MID) : (TARGET_MID - TARGET_FAR);
  localparam int DT_MAX    = (DT_NM_ABS > DT_MF_ABS) ? DT_NM_ABS : DT_MF_ABS;
  localparam int DT_W      = (DT_MAX < 2) ? 1 : $clog2(DT_MAX + 1);
  localparam int MAG_W     = RAW_W + DT_W;

  cal_t              cal;
  logic              en;
  logic              c_vld, c_neg, c_sel;
  logic [MAG_W-1:0]  c_mag;
  logic              q_vld, q_neg, q_sel;
  logic [MAG_W-1:0]  quo;
  logic              r_vld, r_ok;
  logic [OUT_W-1:0]  r_corr;

  logic              skid_valid;
  logic [OUT_W-1:0]  skid_corr;
  logic              skid_ok;
  logic              load_pipe, load_skid_out, load_skid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  tpdc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  tpdc_front #(
    .TARGET_NEAR (TARGET_NEAR),
    .TARGET_MID  (TARGET_MID),
    .TARGET_FAR  (TARGET_FAR),
    .DT_W        (DT_W),
    .MAG_W       (MAG_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid),
    .raw    (raw_mm),
    .cal    (cal),
    .c_vld  (c_vld),
    .c_neg  (c_neg),
    .c_sel  (c_sel),
    .c_mag  (c_mag)
  );

  tpdc_div #(
    .W (MAG_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cal   (cal),
    .d_vld (c_vld),
    .d_neg (c_neg),
    .d_sel (c_sel),
    .d_mag (c_mag),
    .q_vld (q_vld),
    .q_neg (q_neg),
    .q_sel (q_sel),
    .quo   (quo)
  );

  tpdc_back #(
    .TARGET_NEAR (TARGET_NEAR),
    .TARGET_MID  (TARGET_MID),
    .BODY_OFFSET (BODY_OFFSET),
    .DISPLAY_MAX (DISPLAY_MAX),
    .MAG_W       (MAG_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .cal    (cal),
    .q_vld  (q_vld),
    .q_neg  (q_neg),
    .q_sel  (q_sel),
    .quo    (quo),
    .r_vld  (r_vld),
    .r_corr (r_corr),
    .r_ok   (r_ok)
  );

  // The skid entry is only ever full while the output register is full.
  assign load_pipe     = en && (!out_valid || !out_stall);
  assign load_skid     = en && out_valid && out_stall && r_vld;
  assign load_skid_out = !en && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_pipe) begin
        out_valid <= r_vld;
      end else if (load_skid_out) begin
        out_valid <= 1'b1;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (load_skid_out) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pipe) begin
      corrected_mm <= r_corr;
      ok           <= r_ok;
    end else if (load_skid_out) begin
      corrected_mm <= skid_corr;
      ok           <= skid_ok;
    end
    if (load_skid) begin
      skid_corr <= r_corr;
      skid_ok   <= r_ok;
    end
  end

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (corrected_mm == '0))
    else $error("result without calibration is not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((DISPLAY_MAX > 16383) || (int'(corrected_mm) <= DISPLAY_MAX)))
    else $error("result above display maximum");

  a_skid_freeze: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> skid_valid)
    else $error("skid entry dropped while output stalled");
`endif

endmodule

FILE: src/tpdc_cfg.sv
// APB register file and table checks for the distance calibration.
module tpdc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpdc_pkg::DATA_W-1:0]  pwdata,
  output logic [tpdc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tpdc_pkg::cal_t               cal
);
  import tpdc_pkg::*;

  logic [RAW_W-1:0] raw_at_near;
  logic [RAW_W-1:0] raw_at_mid;
  logic [RAW_W-1:0] raw_at_far;
  logic             table_valid;
  logic             body_reference;
  logic [RAW_W-1:0] min_gap_near_mid;
  logic [RAW_W-1:0] min_gap_mid_far;

  reg_idx_t idx;
  logic     wr;
  logic [RAW_W-1:0] span_nm;
  logic [RAW_W-1:0] span_mf;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_at_near      <= RAW_W'(100);
      raw_at_mid       <= RAW_W'(300);
      raw_at_far       <= RAW_W'(500);
      table_valid      <= 1'b0;
      body_reference   <= 1'b0;
      min_gap_near_mid <= '0;
      min_gap_mid_far  <= '0;
    end else if (wr) begin
      case (idx)
        REG_RAW_NEAR:    raw_at_near      <= pwdata[RAW_W-1:0];
        REG_RAW_MID:     raw_at_mid       <= pwdata[RAW_W-1:0];
        REG_RAW_FAR:     raw_at_far       <= pwdata[RAW_W-1:0];
        REG_TABLE_VALID: table_valid      <= pwdata[0];
        REG_BODY_REF:    body_reference   <= pwdata[0];
        REG_MIN_GAP_NM:  min_gap_near_mid <= pwdata[RAW_W-1:0];
        REG_MIN_GAP_MF:  min_gap_mid_far  <= pwdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RAW_NEAR:    prdata = DATA_W'(raw_at_near);
      REG_RAW_MID:     prdata = DATA_W'(raw_at_mid);
      REG_RAW_FAR:     prdata = DATA_W'(raw_at_far);
      REG_TABLE_VALID: prdata = DATA_W'(table_valid);
      REG_BODY_REF:    prdata = DATA_W'(body_reference);
      REG_MIN_GAP_NM:  prdata = DATA_W'(min_gap_near_mid);
      REG_MIN_GAP_MF:  prdata = DATA_W'(min_gap_mid_far);
      default:         prdata = '0;
    endcase
  end

  // The spans wrap when the points are out of order; usable is low then.
  assign span_nm = raw_at_mid - raw_at_near;
  assign span_mf = raw_at_far - raw_at_mid;

  always_comb begin
    cal.raw_near = raw_at_near;
    cal.raw_mid  = raw_at_mid;
    cal.span_nm  = span_nm;
    cal.span_mf  = span_mf;
    cal.body_ref = body_reference;
    cal.usable   = table_valid
                && (raw_at_near < raw_at_mid) && (raw_at_mid < raw_at_far)
                && (span_nm >= min_gap_near_mid) && (span_mf >= min_gap_mid_far);
  end

endmodule

FILE: src/tpdc_front.sv
// Front pipeline: segment select, offset, multiply and rounding bias.
module tpdc_front #(
  parameter int TARGET_NEAR = 100,
  parameter int TARGET_MID  = 300,
  parameter int TARGET_FAR  = 500,
  parameter int DT_W        = 8,
  parameter int MAG_W       = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [tpdc_pkg::RAW_W-1:0]  raw,
  input  tpdc_pkg::cal_t              cal,
  output logic                        c_vld,
  output logic                        c_neg,
  output logic                        c_sel,
  output logic [MAG_W-1:0]            c_mag
);
  import tpdc_pkg::*;

  localparam int PROD_W = RAW_W + DT_W + 2;
  localparam logic signed [DT_W:0] DT_NM = (DT_W+1)'(TARGET_MID - TARGET_NEAR);
  localparam logic signed [DT_W:0] DT_MF = (DT_W+1)'(TARGET_FAR - TARGET_MID);

  logic                     a_vld, a_sel;
  logic signed [RAW_W:0]    a_diff;
  logic                     b_vld, b_sel;
  logic signed [PROD_W-1:0] b_prod;

  logic                     sel_next;
  logic [RAW_W-1:0]         base;
  logic signed [RAW_W:0]    diff_next;
  logic signed [DT_W:0]     dt;
  logic [PROD_W-1:0]        prod_abs;
  logic [RAW_W-1:0]         span;

  // sel high picks the near/mid segment.
  assign sel_next  = raw <= cal.raw_mid;
  assign base      = sel_next ? cal.raw_near : cal.raw_mid;
  assign diff_next = signed'({1'b0, raw}) - signed'({1'b0, base});
  assign dt        = a_sel ? DT_NM : DT_MF;
  assign prod_abs  = b_prod[PROD_W-1] ? PROD_W'(-b_prod) : PROD_W'(b_prod);
  assign span      = b_sel ? cal.span_nm : cal.span_mf;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sel  <= sel_next;
      a_diff <= diff_next;
      b_sel  <= a_sel;
      b_prod <= a_diff * dt;
      c_sel  <= b_sel;
      c_neg  <= b_prod[PROD_W-1];
      // Magnitude plus half the span; the sign goes back on after division.
      c_mag  <= prod_abs[MAG_W-1:0] + MAG_W'(span[RAW_W-1:1]);
    end
  end

endmodule

FILE: src/tpdc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tpdc_div #(
  parameter int W = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  tpdc_pkg::cal_t              cal,
  input  logic                        d_vld,
  input  logic                        d_neg,
  input  logic                        d_sel,
  input  logic [W-1:0]                d_mag,
  output logic                        q_vld,
  output logic                        q_neg,
  output logic                        q_sel,
  output logic [W-1:0]                quo
);
  import tpdc_pkg::*;

  logic             vld [W+1];
  logic             neg [W+1];
  logic             sel [W+1];
  logic [RAW_W-1:0] rem [W+1];
  logic [W-1:0]     dq  [W+1];

  assign vld[0] = d_vld;
  assign neg[0] = d_neg;
  assign sel[0] = d_sel;
  assign rem[0] = '0;
  assign dq[0]  = d_mag;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RAW_W:0]   trial;
    logic [RAW_W:0]   dvs;
    logic             ge;
    logic [RAW_W:0]   diff;

    // The user must keep configuration static while items are in flight; the block
    // itself does not enforce it. The span is picked again from the segment bit at every stage.
    assign dvs   = {1'b0, (sel[k] ? cal.span_nm : cal.span_mf)};
    assign trial = {rem[k], dq[k][W-1]};
    assign ge    = trial >= dvs;
    assign diff  = trial - dvs;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg[k+1] <= neg[k];
        sel[k+1] <= sel[k];
        rem[k+1] <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
        dq[k+1]  <= {dq[k][W-2:0], ge};
      end
    end
  end

  assign q_vld = vld[W];
  assign q_neg = neg[W];
  assign q_sel = sel[W];
  assign quo   = dq[W];

endmodule

FILE: src/tpdc_back.sv
// Back end: sign and base restore, clamp, body offset, final clamp and zero output when the table is unusable.
module tpdc_back #(
  parameter int TARGET_NEAR = 100,
  parameter int TARGET_MID  = 300,
  parameter int BODY_OFFSET = 75,
  parameter int DISPLAY_MAX = 9999,
  parameter int MAG_W       = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  tpdc_pkg::cal_t              cal,
  input  logic                        q_vld,
  input  logic                        q_neg,
  input  logic                        q_sel,
  input  logic [MAG_W-1:0]            quo,
  output logic                        r_vld,
  output logic [tpdc_pkg::OUT_W-1:0]  r_corr,
  output logic                        r_ok
);
  import tpdc_pkg::*;

  localparam int VW     = MAG_W + 2;
  localparam int DISP_W = $clog2(DISPLAY_MAX + 1);
  localparam int SUM_W  = $clog2(DISPLAY_MAX + BODY_OFFSET + 1);

  logic signed [VW-1:0] q_ext;
  logic signed [VW-1:0] ta;
  logic signed [VW-1:0] v;
  logic [DISP_W-1:0]    clamp1_next;
  logic [DISP_W-1:0]    clamp1;
  logic [SUM_W-1:0]     sum;
  logic [DISP_W-1:0]    clamp2;

  assign q_ext = signed'({2'b00, quo});
  assign ta    = q_sel ? VW'(TARGET_NEAR) : VW'(TARGET_MID);
  assign v     = q_neg ? (ta - q_ext) : (ta + q_ext);

  always_comb begin
    if (v[VW-1]) begin
      clamp1_next = '0;
    end else if (v > VW'(DISPLAY_MAX)) begin
      clamp1_next = DISP_W'(DISPLAY_MAX);
    end else begin
      clamp1_next = v[DISP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (en) begin
      r_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp1 <= clamp1_next;
    end
  end

  assign sum    = SUM_W'(clamp1) + (cal.body_ref ? SUM_W'(BODY_OFFSET) : SUM_W'(0));
  assign clamp2 = (sum > SUM_W'(DISPLAY_MAX)) ? DISP_W'(DISPLAY_MAX) : sum[DISP_W-1:0];
  assign r_ok   = cal.usable;
  assign r_corr = cal.usable ? OUT_W'(clamp2) : '0;

endmodule

FILE: verif/three_point_distance_calibration_test.sv
// Self-checking testbench for the three-point distance calibration block.
`timescale 1ns / 1ps

module three_point_distance_calibration_test;
  import tpdc_pkg::*;

  localparam int TARGET_NEAR = 100;
  localparam int TARGET_MID  = 300;
  localparam int TARGET_FAR  = 500;
  localparam int BODY_OFFSET = 75;
  localparam int DISPLAY_MAX = 9999;
  // The first register index past the end of the register list.
  localparam int UNUSED_REG_IDX = 7;
  localparam int LATENCY_WAIT = 60;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OUT_W-1:0] mm;
    logic             ok;
  } reading_t;

  // Predicts every calibrated reading and checks the block's results in order.
  class calibration_scoreboard;
    bit [RAW_W-1:0] raw_near = 100;
    bit [RAW_W-1:0] raw_mid  = 300;
    bit [RAW_W-1:0] raw_far  = 500;
    bit             table_valid = 0;
    bit             body_ref = 0;
    bit [RAW_W-1:0] gap_near_mid = 0;
    bit [RAW_W-1:0] gap_mid_far = 0;
    reading_t       expected_readings[$];
    int             failures = 0;

    function void set_register(int idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_RAW_NEAR:    raw_near = value[RAW_W-1:0];
        REG_RAW_MID:     raw_mid = value[RAW_W-1:0];
        REG_RAW_FAR:     raw_far = value[RAW_W-1:0];
        REG_TABLE_VALID: table_valid = value[0];
        REG_BODY_REF:    body_ref = value[0];
        REG_MIN_GAP_NM:  gap_near_mid = value[RAW_W-1:0];
        REG_MIN_GAP_MF:  gap_mid_far = value[RAW_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_display(longint v);
      if (v < 0) return 0;
      if (v > DISPLAY_MAX) return DISPLAY_MAX;
      return v;
    endfunction

    // Rounds half away from zero, then truncates toward zero.
    function longint segment_value(longint r, longint ra, longint ta, longint rb, longint tb);
      longint span;
      longint num;
      span = rb - ra;
      num = (r - ra) * (tb - ta);
      if (num >= 0) num += span / 2;
      else num -= span / 2;
      return clamp_display(ta + num / span);
    endfunction

    function bit table_usable();
      if (!table_valid) return 0;
      if (!(raw_near < raw_mid && raw_mid < raw_far)) return 0;
      if (raw_mid - raw_near < gap_near_mid) return 0;
      if (raw_far - raw_mid < gap_mid_far) return 0;
      return 1;
    endfunction

    function reading_t predict_reading(logic [RAW_W-1:0] raw);
      reading_t r;
      longint v;
      r.mm = '0;
      r.ok = 1'b0;
      if (!table_usable()) return r;
      if (raw <= raw_mid)
        v = segment_value(raw, raw_near, TARGET_NEAR, raw_mid, TARGET_MID);
      else
        v = segment_value(raw, raw_mid, TARGET_MID, raw_far, TARGET_FAR);
      if (body_ref) v += BODY_OFFSET;
      v = clamp_display(v);
      r.mm = OUT_W'(v);
      r.ok = 1'b1;
      return r;
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw);
      expected_readings.push_back(predict_reading(raw));
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_result(logic [OUT_W-1:0] mm, logic ok_bit);
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        flag($sformatf("unexpected result corrected_mm=%0d ok=%0b", mm, ok_bit));
        return;
      end
      exp_r = expected_readings.pop_front();
      if (mm !== exp_r.mm)
        flag($sformatf("corrected_mm: expected %0d, got %0d", exp_r.mm, mm));
      if (ok_bit !== exp_r.ok)
        flag($sformatf("ok: expected %0b, got %0b", exp_r.ok, ok_bit));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [RAW_W-1:0]  raw_mm;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUT_W-1:0]  corrected_mm;
  logic              ok;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  calibration_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit hold_taken = 0;
  // Samples around the default calibration points and the input limits.
  int probe_raws[12] = '{0, 1, 99, 100, 101, 299, 300, 301, 499, 500, 501, 65535};

  three_point_distance_calibration #(
    .TARGET_NEAR(TARGET_NEAR),
    .TARGET_MID(TARGET_MID),
    .TARGET_FAR(TARGET_FAR),
    .BODY_OFFSET(BODY_OFFSET),
    .DISPLAY_MAX(DISPLAY_MAX)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .raw_mm(raw_mm),
    .out_valid(out_valid), .out_stall(out_stall),
    .corrected_mm(corrected_mm), .ok(ok),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: a requested hold-off is counted down here, else random stalls.
  always @(negedge clk) begin
    if (hold_request > 0 && !hold_taken) begin
      hold_left = hold_request;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(corrected_mm, ok);
      if (in_valid && !in_stall) sb.note_sample(raw_mm);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_sample(logic [RAW_W-1:0] raw);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    raw_mm = raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering samples and waits for every outstanding reading.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(idx * 4);
    // Junk above the register's width must be dropped by the block.
    pwdata = (idx == REG_TABLE_VALID || idx == REG_BODY_REF) ?
             {$urandom() & 32'hFFFF_FFFE} | value : {16'($urandom()), value[15:0]};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, pwdata);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_table(int near_pt, int mid_pt, int far_pt, bit valid, bit body,
                           int gap_nm, int gap_mf);
    reg_write(REG_RAW_NEAR, 32'(near_pt & 16'hFFFF));
    reg_write(REG_RAW_MID, 32'(mid_pt & 16'hFFFF));
    reg_write(REG_RAW_FAR, 32'(far_pt & 16'hFFFF));
    reg_write(REG_MIN_GAP_NM, 32'(gap_nm & 16'hFFFF));
    reg_write(REG_MIN_GAP_MF, 32'(gap_mf & 16'hFFFF));
    reg_write(REG_BODY_REF, 32'(body));
    reg_write(REG_TABLE_VALID, 32'(valid));
    reg_write(UNUSED_REG_IDX, $urandom());
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    int sel;
    int off;
    int point;
    sel = $urandom_range(9);
    off = int'($urandom_range(40)) - 20;
    case ($urandom_range(2))
      0: point = sb.raw_near;
      1: point = sb.raw_mid;
      default: point = sb.raw_far;
    endcase
    if (sel < 4) return RAW_W'($urandom());
    if (sel < 8) return RAW_W'(point + off);
    return RAW_W'($urandom_range(2 * int'(sb.raw_far) + 1));
  endfunction

  task automatic random_table();
    int a, b, c, span_nm, span_mf, gnm, gmf;
    if ($urandom_range(1)) begin
      a = $urandom_range(3000);
      b = a + $urandom_range(1500, 1);
      c = b + $urandom_range(1500, 1);
    end else begin
      a = $urandom_range(65533);
      b = $urandom_range(65534, a + 1);
      c = $urandom_range(65535, b + 1);
    end
    span_nm = b - a;
    span_mf = c - b;
    case ($urandom_range(6))
      0: begin gnm = span_nm + 1; gmf = 0; end
      1: begin gnm = 0; gmf = span_mf + 1; end
      2: begin gnm = 0; gmf = 0; end
      default: begin
        gnm = $urandom_range(span_nm);
        gmf = $urandom_range(span_mf);
      end
    endcase
    set_table(a, b, c, $urandom_range(9) != 0, $urandom_range(1), gnm, gmf);
  endtask

  task automatic run_phase(int setting, int count);
    case (setting % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 55; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 55; end
      default: begin idle_pct = 32; stall_pct = 32; end
    endcase
    // A long receiver hold-off lets the block fill up and stall its input.
    if (setting == 0) hold_request = 300;
    for (int i = 0; i < count; i++) begin
      send_sample(pick_raw());
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    raw_mm = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Table not loaded after reset: every sample reads zero with ok low.
    send_sample(16'd0);
    send_sample(16'hFFFF);
    drain();
    reg_write(REG_TABLE_VALID, 32'd1);
    foreach (probe_raws[k])
      send_sample(RAW_W'(probe_raws[k]));
    drain();
    // Body offset lifts a floored sample and cannot push past the display limit.
    reg_write(REG_BODY_REF, 32'd1);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd300);
    drain();
    set_table(0, 1, 65535, 1'b1, 1'b0, 1, 65534);
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'd2);
    send_sample(16'hFFFF);
    drain();

    for (int s = 0; s < 12; s++) begin
      case (s)
        0: set_table(100, 300, 500, 1'b1, 1'b0, 0, 0);
        1: set_table(0, 32768, 65535, 1'b1, 1'b1, 32768, 32767);
        2: set_table(1000, 2000, 3000, 1'b1, 1'b0, 1001, 0);
        3: set_table(1000, 3000, 3000, 1'b1, 1'b1, 0, 0);
        4: set_table(4000, 3000, 5000, 1'b1, 1'b0, 0, 0);
        5: set_table(65533, 65534, 65535, 1'b1, 1'b1, 1, 1);
        default: random_table();
      endcase
      run_phase(s, (s >= 2 && s <= 4) ? 40 : 125);
    end

    repeat (LATENCY_WAIT) @(posedge clk);
    if (sb.pending() != 0) sb.flag($sformatf("%0d readings never arrived", sb.pending()));
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tpdc_pkg.sv
src/tpdc_cfg.sv
src/tpdc_front.sv
src/tpdc_div.sv
src/tpdc_back.sv
src/three_point_distance_calibration.sv
verif/three_point_distance_calibration_test.sv
